// File: sv/csdte_pkg.sv
// ----------------------------------------------------------------------------
// csdte_pkg
// Shared types and constants of the step delta trace encoder: payload structs,
// configuration register indexes, record fields and serializer phases.
// ----------------------------------------------------------------------------
package csdte_pkg;

    localparam int WORD_W     = 16;
    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [WORD_W-1:0] LONG_STEP_FLAG      = 16'h8000;
    localparam logic [WORD_W-1:0] STATUS_CHANGED_FLAG = 16'h0080;
    localparam int                LEN_SHIFT           = 8;
    localparam logic [63:0]       SHORT_STEP_LIMIT    = 64'h0000_0000_FFFF_FFFF;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WRITE_ENABLE    = 8'd0,
        CFG_COMPRESS_ENABLE = 8'd1,
        CFG_MAGIC_FULL      = 8'd2,
        CFG_MAGIC_DELTA     = 8'd3
    } cfg_index_t;

    // one executed cpu step
    typedef struct packed {
        logic [63:0] regs_low;
        logic [63:0] regs_high;
        logic [15:0] status_word;
        logic [15:0] insn_first;
        logic [15:0] insn_second;
        logic [15:0] insn_third;
        logic [1:0]  insn_len;
    } in_item_t;

    // one trace record word
    typedef struct packed {
        logic [15:0] out_word;
        logic        record_end;
    } out_item_t;

    // record captured at the input transaction, handed to the serializer
    typedef struct packed {
        logic                              is_full;
        logic                              long_step;
        logic                              stat_chg;
        logic [31:0]                       magic;
        logic [63:0]                       step;
        logic [WORD_W-1:0]                 mask;
        logic [WORD_W-1:0]                 status;
        logic [2:0][WORD_W-1:0]            insn;
        logic [1:0]                        insn_cnt;
        logic [NUM_REGS-1:0][WORD_W-1:0]   regs;
        logic [NUM_REGS-1:0]               reg_pend;
    } rec_t;

    // serializer phases
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_MAGIC,
        PH_STATUS_FULL,
        PH_STEP,
        PH_PC,
        PH_MASK,
        PH_INSN,
        PH_REG,
        PH_STATUS_DELTA
    } phase_t;

endpackage

// File: sv/csdte_lane.sv
// ----------------------------------------------------------------------------
// csdte_lane
// One compare lane: keeps the stored copy of one value and flags a change
// against the incoming value; the copy follows the input on update.
// ----------------------------------------------------------------------------
module csdte_lane
    import csdte_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [WORD_W-1:0] value,
    input  logic              update,
    output logic              changed
);

    logic [WORD_W-1:0] prior_reg;
    logic [WORD_W-1:0] prior_next;

    // change detect
    assign changed = (prior_reg != value);

    // stored copy
    always_comb
    begin
        prior_next = prior_reg;
        if (update)
        begin
            prior_next = value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_reg <= '0;
        end
        else
        begin
            prior_reg <= prior_next;
        end
    end

endmodule

// File: sv/csdte_merge.sv
// ----------------------------------------------------------------------------
// csdte_merge
// Merging stage: folds the lane change flags, status change, instruction
// length and long step flag into the delta mask word and pending set.
// ----------------------------------------------------------------------------
module csdte_merge
    import csdte_pkg::*;
#(
    parameter int TRACKED_REGS = 7
)
(
    input  logic [TRACKED_REGS-1:0] reg_chg,
    input  logic                    stat_chg,
    input  logic [1:0]              insn_cnt,
    input  logic                    long_step,
    output logic [WORD_W-1:0]       mask,
    output logic [NUM_REGS-1:0]     reg_pend
);

    // pending set, one bit per tracked register
    always_comb
    begin
        reg_pend = '0;
        for (int i = 0; i < TRACKED_REGS; i++)
        begin
            reg_pend[i] = reg_chg[i];
        end
    end

    // mask word
    always_comb
    begin
        mask = {{(WORD_W-NUM_REGS){1'b0}}, reg_pend};
        mask = mask | (WORD_W'(insn_cnt) << LEN_SHIFT);
        if (stat_chg)
        begin
            mask = mask | STATUS_CHANGED_FLAG;
        end
        if (long_step)
        begin
            mask = mask | LONG_STEP_FLAG;
        end
    end

endmodule

// File: sv/csdte_emit.sv
// ----------------------------------------------------------------------------
// csdte_emit
// Record serializer: walks the captured record one word per cycle, unless out_ready
// stalls it, into an output register, picking changed registers by lowest pending bit.
// ----------------------------------------------------------------------------
module csdte_emit
    import csdte_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  rec_t      rec,
    output logic      can_load,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    phase_t              phase_reg, phase_next, seq_phase;
    logic [2:0]          idx_reg, idx_next, seq_idx;
    logic [NUM_REGS-1:0] pend_reg, pend_next, pend_clr;
    rec_t                rec_reg;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_data_reg, out_data_next;
    logic                adv;
    logic [REG_IDX_W-1:0] pick;
    logic [REG_IDX_W-1:0] ridx;
    logic [2:0]          insn_last;
    logic [WORD_W-1:0]   cur_word;

    // advance when a word can enter the output register
    assign adv      = (phase_reg != PH_IDLE) && (!out_valid_reg || out_ready);
    assign can_load = (phase_reg == PH_IDLE) || (adv && (seq_phase == PH_IDLE));

    // lowest pending register
    always_comb
    begin
        pick = '0;
        for (int i = NUM_REGS - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                pick = REG_IDX_W'(i);
            end
        end
        pend_clr = pend_reg & ~(NUM_REGS'(1) << pick);
    end

    assign insn_last = 3'({1'b0, rec_reg.insn_cnt} - 3'd1);

    // next state
    always_comb
    begin
        seq_phase = phase_reg;
        seq_idx   = idx_reg;
        pend_next = pend_reg;
        case (phase_reg)
            PH_MAGIC:
            begin
                if (idx_reg == 3'd0)
                begin
                    if (rec_reg.is_full)
                    begin
                        seq_phase = PH_STATUS_FULL;
                    end
                    else
                    begin
                        seq_phase = PH_STEP;
                        seq_idx   = rec_reg.long_step ? 3'd3 : 3'd1;
                    end
                end
                else
                begin
                    seq_idx = idx_reg - 3'd1;
                end
            end
            PH_STATUS_FULL:
            begin
                seq_phase = PH_STEP;
                seq_idx   = 3'd3;
            end
            PH_STEP:
            begin
                if (idx_reg == 3'd0)
                begin
                    seq_phase = rec_reg.is_full ? PH_INSN : PH_PC;
                end
                else
                begin
                    seq_idx = idx_reg - 3'd1;
                end
            end
            PH_PC:
            begin
                seq_phase = PH_MASK;
            end
            PH_MASK:
            begin
                seq_phase = PH_INSN;
                seq_idx   = 3'd0;
            end
            PH_INSN:
            begin
                if (idx_reg == insn_last)
                begin
                    seq_idx = 3'd0;
                    if (rec_reg.is_full || (pend_reg != '0))
                    begin
                        seq_phase = PH_REG;
                    end
                    else if (rec_reg.stat_chg)
                    begin
                        seq_phase = PH_STATUS_DELTA;
                    end
                    else
                    begin
                        seq_phase = PH_IDLE;
                    end
                end
                else
                begin
                    seq_idx = idx_reg + 3'd1;
                end
            end
            PH_REG:
            begin
                if (rec_reg.is_full)
                begin
                    if (idx_reg == 3'(NUM_REGS - 1))
                    begin
                        seq_phase = PH_IDLE;
                    end
                    else
                    begin
                        seq_idx = idx_reg + 3'd1;
                    end
                end
                else
                begin
                    pend_next = pend_clr;
                    if (pend_clr == '0)
                    begin
                        seq_phase = rec_reg.stat_chg ? PH_STATUS_DELTA : PH_IDLE;
                    end
                end
            end
            PH_STATUS_DELTA:
            begin
                seq_phase = PH_IDLE;
            end
            default:
            begin
                seq_phase = PH_IDLE;
            end
        endcase

        phase_next = phase_reg;
        idx_next   = idx_reg;
        if (!adv)
        begin
            pend_next = pend_reg;
        end
        if (load)
        begin
            phase_next = PH_MAGIC;
            idx_next   = 3'd1;
            pend_next  = rec.reg_pend;
        end
        else if (adv)
        begin
            phase_next = seq_phase;
            idx_next   = seq_idx;
        end
    end

    // outputs: current record word
    always_comb
    begin
        ridx = rec_reg.is_full ? idx_reg : pick;
        case (phase_reg)
            PH_MAGIC:        cur_word = idx_reg[0] ? rec_reg.magic[31:16] : rec_reg.magic[15:0];
            PH_STATUS_FULL:  cur_word = rec_reg.status;
            PH_STEP:         cur_word = rec_reg.step[{idx_reg[1:0], 4'b0000} +: WORD_W];
            PH_PC:           cur_word = rec_reg.regs[NUM_REGS-1];
            PH_MASK:         cur_word = rec_reg.mask;
            PH_INSN:         cur_word = rec_reg.insn[idx_reg[1:0]];
            PH_REG:          cur_word = rec_reg.regs[ridx];
            PH_STATUS_DELTA: cur_word = rec_reg.status;
            default:         cur_word = '0;
        endcase

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (adv)
        begin
            out_valid_next          = 1'b1;
            out_data_next.out_word  = cur_word;
            out_data_next.record_end = (seq_phase == PH_IDLE);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            idx_reg       <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (load)
        begin
            rec_reg <= rec;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: sv/cpu_step_delta_trace_encoder.sv
// ----------------------------------------------------------------------------
// cpu_step_delta_trace_encoder
// The input transaction loads the serializer phase register; the first record
// word then enters the output register. Output: one word per cycle unless
// out_ready stalls; full records have 15 + MAX_INSN_WORDS words, delta 7 to 19.
// Steps are taken while idle or as the last word goes out; with writes disabled a step gives no words.
// Reset: asynchronous, active low; clears counters and stored copies, loads
// register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module cpu_step_delta_trace_encoder
    import csdte_pkg::*;
#(
    parameter int TRACKED_REGS   = 7,
    parameter int MAX_INSN_WORDS = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [1:0] INSN_CNT_MAX = 2'(MAX_INSN_WORDS);

    logic        write_enable_reg, write_enable_next;
    logic        compress_enable_reg, compress_enable_next;
    logic [31:0] magic_full_reg, magic_full_next;
    logic [31:0] magic_delta_reg, magic_delta_next;
    logic [63:0] step_count_reg, step_count_next;
    logic        first_pending_reg, first_pending_next;

    logic                            in_accept;
    logic                            rec_go;
    logic                            is_full;
    logic                            long_step;
    logic                            can_load;
    logic [1:0]                      len_clamp;
    logic [1:0]                      insn_cnt;
    logic [NUM_REGS-1:0][WORD_W-1:0] all_regs;
    logic [TRACKED_REGS-1:0]         reg_chg;
    logic                            stat_chg;
    logic [WORD_W-1:0]               mask;
    logic [NUM_REGS-1:0]             reg_pend;
    rec_t                            rec;

    // input transaction
    assign in_ready  = can_load;
    assign in_accept = in_valid && in_ready;
    assign rec_go    = in_accept && write_enable_reg;
    assign is_full   = first_pending_reg || !compress_enable_reg;
    assign long_step = (step_count_reg >= SHORT_STEP_LIMIT);

    // register file split
    always_comb
    begin
        for (int i = 0; i < NUM_REGS / 2; i++)
        begin
            all_regs[i]              = in_data.regs_low[i*WORD_W +: WORD_W];
            all_regs[i + NUM_REGS/2] = in_data.regs_high[i*WORD_W +: WORD_W];
        end
    end

    // instruction length clamp
    always_comb
    begin
        len_clamp = in_data.insn_len;
        if (len_clamp == 2'd0)
        begin
            len_clamp = 2'd1;
        end
        if (len_clamp > INSN_CNT_MAX)
        begin
            len_clamp = INSN_CNT_MAX;
        end
        insn_cnt = is_full ? INSN_CNT_MAX : len_clamp;
    end

    // compare lanes for tracked registers and status
    for (genvar g = 0; g < TRACKED_REGS; g++)
    begin : g_lane
        csdte_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .value   (all_regs[g]),
            .update  (rec_go && !is_full),
            .changed (reg_chg[g])
        );
    end

    csdte_lane u_status_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .value   (in_data.status_word),
        .update  (rec_go && !is_full),
        .changed (stat_chg)
    );

    // merge lane results
    csdte_merge #(
        .TRACKED_REGS (TRACKED_REGS)
    ) u_merge (
        .reg_chg   (reg_chg),
        .stat_chg  (stat_chg),
        .insn_cnt  (len_clamp),
        .long_step (long_step),
        .mask      (mask),
        .reg_pend  (reg_pend)
    );

    // record capture
    always_comb
    begin
        rec.is_full   = is_full;
        rec.long_step = long_step;
        rec.stat_chg  = stat_chg;
        rec.magic     = is_full ? magic_full_reg : magic_delta_reg;
        rec.step      = step_count_reg;
        rec.mask      = mask;
        rec.status    = in_data.status_word;
        rec.insn[0]   = in_data.insn_first;
        rec.insn[1]   = in_data.insn_second;
        rec.insn[2]   = in_data.insn_third;
        rec.insn_cnt  = insn_cnt;
        rec.regs      = all_regs;
        rec.reg_pend  = reg_pend;
    end

    csdte_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (rec_go),
        .rec       (rec),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // step counter and first record flag
    always_comb
    begin
        step_count_next    = step_count_reg;
        first_pending_next = first_pending_reg;
        if (rec_go)
        begin
            step_count_next = step_count_reg + 64'd1;
            if (is_full)
            begin
                first_pending_next = 1'b0;
            end
        end
    end

    // configuration writes
    assign cfg_ready = 1'b1;

    always_comb
    begin
        write_enable_next    = write_enable_reg;
        compress_enable_next = compress_enable_reg;
        magic_full_next      = magic_full_reg;
        magic_delta_next     = magic_delta_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WRITE_ENABLE:    write_enable_next    = cfg_data[0];
                CFG_COMPRESS_ENABLE: compress_enable_next = cfg_data[0];
                CFG_MAGIC_FULL:      magic_full_next      = cfg_data;
                CFG_MAGIC_DELTA:     magic_delta_next     = cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_enable_reg    <= 1'b1;
            compress_enable_reg <= 1'b0;
            magic_full_reg      <= '0;
            magic_delta_reg     <= '0;
            step_count_reg      <= '0;
            first_pending_reg   <= 1'b1;
        end
        else
        begin
            write_enable_reg    <= write_enable_next;
            compress_enable_reg <= compress_enable_next;
            magic_full_reg      <= magic_full_next;
            magic_delta_reg     <= magic_delta_next;
            step_count_reg      <= step_count_next;
            first_pending_reg   <= first_pending_next;
        end
    end

endmodule

// File: tb/sv/cpu_step_delta_trace_encoder_tb.sv
// ----------------------------------------------------------------------------
// cpu_step_delta_trace_encoder_tb
// Self-checking bench for the step trace encoder. CPU steps go in over a
// valid/ready channel and every trace word that comes out is compared with
// the words that a local encoder predicts: full records, delta records with
// change masks, write disable and clamped instruction lengths, under several
// register settings, random idling on both sides and long output back-pressure.
// ----------------------------------------------------------------------------
module cpu_step_delta_trace_encoder_tb;
    import csdte_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TRACKED_REGS   = 7;
    localparam int MAX_INSN_WORDS = 3;
    localparam int DRAIN_CYCLES   = 4;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int STALL_LIMIT    = 4000;

    // indexes past the register file; writes to them must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 8'hFF;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // local copy of the encoder registers and state
    logic        wr_en;
    logic        cmp_en;
    logic [31:0] tag_full;
    logic [31:0] tag_delta;
    logic [63:0] step_cnt;
    logic [15:0] saved_regs [TRACKED_REGS];
    logic [15:0] saved_status;
    logic        need_full;

    // trace words still to come, oldest first
    out_item_t       trace_words_due [$];
    logic [15:0]     rec_words [$];
    logic [7:0]      cfg_idx_q [$];
    logic [31:0]     cfg_dat_q [$];
    in_item_t        prev_random = '0;

    int errors        = 0;
    int steps_sent    = 0;
    int full_records  = 0;
    int delta_records = 0;
    int words_checked = 0;
    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    cpu_step_delta_trace_encoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // trace encoder prediction
    // ------------------------------------------------------------------------

    function automatic void put_word(input logic [15:0] w);
        rec_words.push_back(w);
    endfunction

    // multi-word value, most significant word first
    function automatic void put_wide(input logic [63:0] v, input int n);
        int k;
        for (k = n - 1; k >= 0; k--)
            put_word(v[16*k +: 16]);
    endfunction

    function automatic void reset_encoder_state();
        int i;
        wr_en        = 1'b1;
        cmp_en       = 1'b0;
        tag_full     = '0;
        tag_delta    = '0;
        step_cnt     = '0;
        saved_status = '0;
        need_full    = 1'b1;
        for (i = 0; i < TRACKED_REGS; i++)
            saved_regs[i] = '0;
    endfunction

    function automatic void apply_cfg(input logic [7:0] idx, input logic [31:0] val);
        case (idx)
            CFG_WRITE_ENABLE:    wr_en     = val[0];
            CFG_COMPRESS_ENABLE: cmp_en    = val[0];
            CFG_MAGIC_FULL:      tag_full  = val;
            CFG_MAGIC_DELTA:     tag_delta = val;
            default:             ;
        endcase
    endfunction

    // expected trace record of one accepted step
    function automatic void encode_step(input in_item_t s);
        logic [15:0] regs [8];
        logic [15:0] insn [3];
        logic [15:0] mask;
        logic [1:0]  n;
        logic        long_step;
        out_item_t   w;
        int          i;
        if (!wr_en)
            return;
        for (i = 0; i < 4; i++)
        begin
            regs[i]     = s.regs_low[16*i +: 16];
            regs[i + 4] = s.regs_high[16*i +: 16];
        end
        insn[0] = s.insn_first;
        insn[1] = s.insn_second;
        insn[2] = s.insn_third;
        n = (s.insn_len == 2'd0) ? 2'd1 : s.insn_len;
        rec_words.delete();
        if (cmp_en && !need_full)
        begin
            // delta record: only what changed since the stored copies
            long_step = (step_cnt >= SHORT_STEP_LIMIT);
            mask = '0;
            for (i = 0; i < TRACKED_REGS; i++)
                if (saved_regs[i] != regs[i])
                    mask[i] = 1'b1;
            if (saved_status != s.status_word)
                mask = mask | STATUS_CHANGED_FLAG;
            mask[LEN_SHIFT +: 2] = n;
            if (long_step)
                mask = mask | LONG_STEP_FLAG;
            put_wide({32'd0, tag_delta}, 2);
            put_wide(step_cnt, long_step ? 4 : 2);
            step_cnt = step_cnt + 64'd1;
            put_word(regs[7]);
            put_word(mask);
            for (i = 0; i < int'(n); i++)
                put_word(insn[i]);
            for (i = 0; i < TRACKED_REGS; i++)
            begin
                if (saved_regs[i] != regs[i])
                begin
                    put_word(regs[i]);
                    saved_regs[i] = regs[i];
                end
            end
            if (saved_status != s.status_word)
            begin
                put_word(s.status_word);
                saved_status = s.status_word;
            end
            delta_records++;
        end
        else
        begin
            // full record: everything, stored copies untouched
            need_full = 1'b0;
            put_wide({32'd0, tag_full}, 2);
            put_word(s.status_word);
            put_wide(step_cnt, 4);
            step_cnt = step_cnt + 64'd1;
            for (i = 0; i < MAX_INSN_WORDS; i++)
                put_word(insn[i]);
            for (i = 0; i < 8; i++)
                put_word(regs[i]);
            full_records++;
        end
        for (i = 0; i < rec_words.size(); i++)
        begin
            w.out_word   = rec_words[i];
            w.record_end = (i == rec_words.size() - 1);
            trace_words_due.push_back(w);
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic in_item_t make_step(input logic [63:0] lo, input logic [63:0] hi,
                                           input logic [15:0] st, input logic [15:0] i1,
                                           input logic [15:0] i2, input logic [15:0] i3,
                                           input logic [1:0] len);
        in_item_t s;
        s.regs_low    = lo;
        s.regs_high   = hi;
        s.status_word = st;
        s.insn_first  = i1;
        s.insn_second = i2;
        s.insn_third  = i3;
        s.insn_len    = len;
        return s;
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly a plausible next step with a few changed registers, sometimes noise
    function automatic in_item_t next_random_step();
        in_item_t s;
        int       i;
        s = prev_random;
        if ($urandom_range(0, 9) == 0)
        begin
            s.regs_low    = {$urandom, $urandom};
            s.regs_high   = {$urandom, $urandom};
            s.status_word = 16'($urandom);
        end
        else
        begin
            for (i = 0; i < 4; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    s.regs_low[16*i +: 16] = pick_value();
                if (i < 3 && $urandom_range(0, 3) == 0)
                    s.regs_high[16*i +: 16] = pick_value();
            end
            // program counter walks forward most of the time
            if ($urandom_range(0, 7) == 0)
                s.regs_high[63:48] = pick_value();
            else
                s.regs_high[63:48] = s.regs_high[63:48] + 16'(2 * $urandom_range(1, 3));
            if ($urandom_range(0, 3) == 0)
                s.status_word = pick_value();
        end
        s.insn_first  = 16'($urandom);
        s.insn_second = 16'($urandom);
        s.insn_third  = 16'($urandom);
        s.insn_len    = 2'($urandom_range(0, 3));
        prev_random = s;
        return s;
    endfunction

    // one step transaction, valid kept high after acceptance for back-to-back steps
    task automatic offer_step(input in_item_t s);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < in_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do
            @(posedge clk);
        while (!in_ready);
        steps_sent++;
        encode_step(s);
    endtask

    // sender pauses until every predicted word has come out
    task automatic wait_results();
        in_valid <= 1'b0;
        while (trace_words_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void stage_cfg(input logic [7:0] idx, input logic [31:0] val);
        cfg_idx_q.push_back(idx);
        cfg_dat_q.push_back(val);
    endfunction

    // write the staged registers back to back, block idle
    task automatic commit_cfg();
        cfg_valid <= 1'b1;
        cfg_index <= cfg_idx_q[0];
        cfg_data  <= cfg_dat_q[0];
        while (cfg_idx_q.size() != 0)
        begin
            do
                @(posedge clk);
            while (!cfg_ready);
            apply_cfg(cfg_idx_q[0], cfg_dat_q[0]);
            void'(cfg_idx_q.pop_front());
            void'(cfg_dat_q.pop_front());
            if (cfg_idx_q.size() != 0)
            begin
                cfg_index <= cfg_idx_q[0];
                cfg_data  <= cfg_dat_q[0];
            end
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random_steps(input int count);
        int k;
        for (k = 0; k < count; k++)
        begin
            if (k == count / 2)
                wait_results();
            offer_step(next_random_step());
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // compression on before any step: the first record is still full
    task automatic test_first_step();
        stage_cfg(CFG_COMPRESS_ENABLE, 32'd1);
        commit_cfg();
        offer_step(make_step('0, '0, '0, '0, '0, '0, 2'd1));
        offer_step(make_step('0, '0, '0, '0, '0, '0, 2'd1));
        wait_results();
    endtask

    // change masks, clamped lengths, untracked program counter
    task automatic test_delta_records();
        stage_cfg(CFG_MAGIC_FULL, 32'hFFFF_FFFF);
        stage_cfg(CFG_MAGIC_DELTA, 32'h1234_5678);
        commit_cfg();
        offer_step(make_step('1, '1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3));
        offer_step(make_step('1, '1, 16'hFFFF, 16'h1111, 16'h2222, 16'h3333, 2'd0));
        offer_step(make_step('1, '1, 16'h0000, 16'h4444, 16'h5555, 16'h6666, 2'd2));
        offer_step(make_step('1, 64'h0000_FFFF_FFFF_FFFF, 16'h0000, 16'h7777, 16'h8888,
                             16'h9999, 2'd1));
        offer_step(make_step(64'hFFFF_FFFF_FFFF_0000, 64'h0000_FFFF_FFFF_FFFF, 16'h0000,
                             16'hAAAA, 16'hBBBB, 16'hCCCC, 2'd3));
        offer_step(make_step(64'hFFFF_FFFF_FFFF_0000, 64'h0000_0000_FFFF_FFFF, 16'h0000,
                             16'hDDDD, 16'hEEEE, 16'h0F0F, 2'd2));
        offer_step(make_step(64'hAAAA_5555_AAAA_5555, 64'h5555_AAAA_5555_AAAA, 16'hA5A5,
                             16'h5A5A, 16'hA5A5, 16'h5A5A, 2'd3));
        offer_step(make_step(64'h5555_AAAA_5555_AAAA, 64'hAAAA_5555_AAAA_5555, 16'h5A5A,
                             16'hA5A5, 16'h5A5A, 16'hA5A5, 2'd3));
        offer_step(make_step(64'h5555_AAAA_5555_AAAA, 64'hAAAA_0000_AAAA_5555, 16'h5A5A,
                             16'h0001, 16'h0002, 16'h0003, 2'd1));
        wait_results();
    endtask

    // compression off: every record full, whatever the length says
    task automatic test_full_records();
        stage_cfg(CFG_COMPRESS_ENABLE, 32'd0);
        stage_cfg(CFG_MAGIC_FULL, 32'h0000_0000);
        commit_cfg();
        offer_step(make_step('0, '0, '0, '0, '0, '0, 2'd0));
        offer_step(make_step('1, '1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd1));
        offer_step(make_step(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 16'h8001,
                             16'h1357, 16'h2468, 16'h9BDF, 2'd2));
        offer_step(make_step(64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF, 16'h7FFE,
                             16'hECA8, 16'hDB97, 16'h6420, 2'd3));
        wait_results();
    endtask

    // writes off: no words and no state change; stray and oversized writes
    task automatic test_write_disable();
        stage_cfg(CFG_WRITE_ENABLE, 32'hFFFF_FFFE);
        stage_cfg(CFG_SPARE_FIRST, 32'hFFFF_FFFF);
        stage_cfg(CFG_SPARE_LAST, 32'hFFFF_FFFF);
        commit_cfg();
        offer_step(make_step('1, '1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3));
        offer_step(make_step('0, '0, '0, '0, '0, '0, 2'd0));
        offer_step(make_step(64'hAAAA_AAAA_AAAA_AAAA, '0, 16'h00FF, '0, '0, '0, 2'd2));
        wait_results();
        stage_cfg(CFG_WRITE_ENABLE, 32'hFFFF_FFFF);
        stage_cfg(CFG_COMPRESS_ENABLE, 32'hFFFF_FFFF);
        commit_cfg();
        offer_step(make_step(64'h5555_AAAA_5555_AAAA, 64'hAAAA_0000_AAAA_5555, 16'h5A5A,
                             16'h0BAD, 16'h0C0D, 16'h0E0F, 2'd2));
        offer_step(make_step('0, '1, 16'hFFFF, 16'h0001, 16'h0002, 16'h0003, 2'd3));
        wait_results();
    endtask

    // output held off for a long stretch while steps keep coming
    task automatic test_backpressure();
        int k;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        hold_req++;
        for (k = 0; k < 24; k++)
            offer_step(next_random_step());
        wait_results();
    endtask

    // random steps under each idling mix and register setting
    task automatic test_random_phases();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        stage_cfg(CFG_COMPRESS_ENABLE, 32'd1);
        stage_cfg(CFG_MAGIC_FULL, $urandom);
        stage_cfg(CFG_MAGIC_DELTA, $urandom);
        commit_cfg();
        run_random_steps(96);
        wait_results();

        in_idle_pct = 80;
        stage_cfg(CFG_COMPRESS_ENABLE, 32'd0);
        stage_cfg(CFG_MAGIC_FULL, 32'hFFFF_FFFF);
        stage_cfg(CFG_MAGIC_DELTA, 32'h0000_0000);
        commit_cfg();
        run_random_steps(96);
        wait_results();

        in_idle_pct   = 0;
        out_stall_pct = 80;
        stage_cfg(CFG_COMPRESS_ENABLE, 32'd1);
        stage_cfg(CFG_MAGIC_FULL, 32'h0000_0000);
        stage_cfg(CFG_MAGIC_DELTA, 32'hFFFF_FFFF);
        commit_cfg();
        run_random_steps(96);
        wait_results();

        in_idle_pct   = 12;
        out_stall_pct = 12;
        stage_cfg(CFG_WRITE_ENABLE, 32'd1);
        stage_cfg(CFG_MAGIC_FULL, $urandom);
        stage_cfg(CFG_MAGIC_DELTA, $urandom);
        commit_cfg();
        run_random_steps(48);
        wait_results();
        stage_cfg(CFG_COMPRESS_ENABLE, 32'd0);
        commit_cfg();
        run_random_steps(24);
        wait_results();
        stage_cfg(CFG_COMPRESS_ENABLE, 32'd1);
        commit_cfg();
        run_random_steps(24);
        wait_results();
    endtask

    // ------------------------------------------------------------------------
    // output side: ready pattern, word check, watchdog
    // ------------------------------------------------------------------------

    // receiver ready, with a long hold on request
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = RX_HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end

    // compare each output transaction with the oldest predicted word
    always @(posedge clk)
    begin : check_words
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            words_checked++;
            if (trace_words_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, got %h end %b",
                         $time, out_data.out_word, out_data.record_end);
            end
            else
            begin
                want = trace_words_due.pop_front();
                if (out_data.out_word !== want.out_word)
                begin
                    errors++;
                    $display("%0t: out_word expected %h got %h",
                             $time, want.out_word, out_data.out_word);
                end
                if (out_data.record_end !== want.record_end)
                begin
                    errors++;
                    $display("%0t: record_end expected %b got %b",
                             $time, want.record_end, out_data.record_end);
                end
            end
        end
    end

    // no transaction of any kind for too long ends the run
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d words outstanding",
                     $time, STALL_LIMIT, trace_words_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        reset_encoder_state();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_first_step();
        test_delta_records();
        test_full_records();
        test_write_disable();
        test_backpressure();
        test_random_phases();
        wait_results();
        $display("%0d steps sent: %0d full and %0d delta records, %0d words checked",
                 steps_sent, full_records, delta_records, words_checked);
        $display("idling mixes none, sender 80, receiver 80, both 12; one long output hold");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
